// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the noise generator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, switched off while reset is high.
`define CNSG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Checked on every rising edge, reset included.
`define CNSG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/cnsg_pkg.sv =====
// ----------------------------------------------------------------------------
// cnsg_pkg
// Types and constants of the counter-based noise sample generator.
// ----------------------------------------------------------------------------
`default_nettype none

package cnsg_pkg;

   // payload types
   typedef logic [31:0]        sample_index_type;
   typedef logic signed [15:0] noise_sample_type;
   typedef logic signed [18:0] gain_type;

   // register file
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STREAM_SEED    = 3'd0,
      CSR_FIELD_NUMBER   = 3'd1,
      CSR_CHANNEL_NUMBER = 3'd2,
      CSR_GAIN           = 3'd3
   } csr_index_type;

   // identity limits
   localparam logic [32:0] FIELD_COUNT   = 33'd256;
   localparam logic [32:0] CHANNEL_COUNT = 33'd256;

   // splitmix64 constants
   localparam logic [63:0] INDEX_MULT = 64'hd1342543de82ef95;
   localparam logic [63:0] MIX_ADD    = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_M1     = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_M2     = 64'h94d049bb133111eb;

   // gain and output scaling
   localparam gain_type         GAIN_LIMIT  = 19'sd131072;
   localparam gain_type         GAIN_RESET  = 19'sd32768;
   localparam logic [34:0]      ROUND_HALF  = 35'd16384;
   localparam noise_sample_type SAMPLE_MAX  = 16'sh7FFF;
   localparam noise_sample_type SAMPLE_MIN  = 16'sh8000;
   localparam int               RMAG_W      = 18;

   // pipeline depth
   localparam int STAGE_COUNT = 10;

endpackage : cnsg_pkg

`default_nettype wire

// ===== hw/rtl/cnsg_req_if.sv =====
// ----------------------------------------------------------------------------
// cnsg_req_if
// Request channel: sample index and block-end flag, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cnsg_req_if;
   import cnsg_pkg::*;

   logic             valid;
   logic             ready;
   sample_index_type sample_index;
   logic             last_in;

   modport source (output valid, output sample_index, output last_in, input ready);
   modport sink   (input valid, input sample_index, input last_in, output ready);

endinterface : cnsg_req_if

`default_nettype wire

// ===== hw/rtl/cnsg_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cnsg_rsp_if
// Response channel: scaled noise sample and block-end flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface cnsg_rsp_if;
   import cnsg_pkg::*;

   logic             valid;
   logic             ready;
   noise_sample_type noise_sample;
   logic             last_out;

   modport source (output valid, output noise_sample, output last_out, input ready);
   modport sink   (input valid, input noise_sample, input last_out, output ready);

endinterface : cnsg_rsp_if

`default_nettype wire

// ===== hw/rtl/counter_noise_sample_generator_top.sv =====
// ----------------------------------------------------------------------------
// counter_noise_sample_generator_top
// Counter-based splitmix64 noise: one gain-scaled int16 sample per index.
// ----------------------------------------------------------------------------
//
//   channel   dir   beat payload                      handshake
//   -------   ---   ------------------------------    ---------------
//   req_if    in    sample_index[31:0], last_in       valid / ready
//   rsp_if    out   noise_sample[15:0] s, last_out    valid / ready
//   csr_*     in    csr_index[2:0], csr_wdata[63:0]   csr_we, no wait
//
// One beat per clock sustained while rsp ready stays high; requests run to the
// response through the ten-stage pipeline (three 64-bit multiplies split into
// 32x32 partial products, each followed by a summing stage).
// Synchronous active-high reset clears the valid bits and loads register
// defaults (seed 0, field 0, channel 0, gain 1.0 in Q15).
// A stalled response holds its stage; bubbles further up still collapse,
// so req ready stays high while any stage is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module counter_noise_sample_generator_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [cnsg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [cnsg_pkg::CSR_DATA_W-1:0]    csr_wdata,
   cnsg_req_if.sink                                req_if,
   cnsg_rsp_if.source                              rsp_if
);
   import cnsg_pkg::*;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [63:0] seed_ff,    seed_in;
   logic [7:0]  field_ff,   field_in;
   logic [7:0]  channel_ff, channel_in;
   gain_type    gain_ff,    gain_in;
   gain_type    gain_wr;
   logic [63:0] identity;

   // out-of-range values are clamped on the way in, so the datapath
   // only ever sees legal settings
   always_comb begin
      seed_in    = seed_ff;
      field_in   = field_ff;
      channel_in = channel_ff;
      gain_in    = gain_ff;
      gain_wr    = gain_type'(csr_wdata[18:0]);
      if (csr_we) begin
         unique case (csr_index)
            CSR_STREAM_SEED: begin
               seed_in = csr_wdata;
            end
            CSR_FIELD_NUMBER: begin
               if ({25'd0, csr_wdata[7:0]} >= FIELD_COUNT) begin
                  field_in = 8'(FIELD_COUNT - 33'd1);
               end else begin
                  field_in = csr_wdata[7:0];
               end
            end
            CSR_CHANNEL_NUMBER: begin
               if ({25'd0, csr_wdata[7:0]} >= CHANNEL_COUNT) begin
                  channel_in = 8'(CHANNEL_COUNT - 33'd1);
               end else begin
                  channel_in = csr_wdata[7:0];
               end
            end
            CSR_GAIN: begin
               if (gain_wr > GAIN_LIMIT) begin
                  gain_in = GAIN_LIMIT;
               end else if (gain_wr < -GAIN_LIMIT) begin
                  gain_in = -GAIN_LIMIT;
               end else begin
                  gain_in = gain_wr;
               end
            end
            default: begin
               // unknown index: write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff    <= '0;
         field_ff   <= '0;
         channel_ff <= '0;
         gain_ff    <= GAIN_RESET;
      end else begin
         seed_ff    <= seed_in;
         field_ff   <= field_in;
         channel_ff <= channel_in;
         gain_ff    <= gain_in;
      end
   end

   // stream identity: seed ^ field<<32 ^ channel<<56
   assign identity = seed_ff ^ {channel_ff, 16'd0, field_ff, 32'd0};

   // ---------------------------------------------------------------------
   // Pipeline flow control
   // A stage loads when it is empty or the stage after it moves.
   // ---------------------------------------------------------------------
   logic [STAGE_COUNT-1:0] stage_en;
   logic [STAGE_COUNT-1:0] valid_ff,     valid_in;
   logic [STAGE_COUNT-1:0] last_pipe_ff, last_pipe_in;

   always_comb begin
      stage_en[STAGE_COUNT-1] = !valid_ff[STAGE_COUNT-1] || rsp_if.ready;
      for (int i = STAGE_COUNT - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
   end

   always_comb begin
      valid_in[0]     = stage_en[0] ? req_if.valid   : valid_ff[0];
      last_pipe_in[0] = stage_en[0] ? req_if.last_in : last_pipe_ff[0];
      for (int i = 1; i < STAGE_COUNT; i++) begin
         valid_in[i]     = stage_en[i] ? valid_ff[i-1]     : valid_ff[i];
         last_pipe_in[i] = stage_en[i] ? last_pipe_ff[i-1] : last_pipe_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_pipe_ff <= last_pipe_in;
   end

   assign req_if.ready = stage_en[0];

   // ---------------------------------------------------------------------
   // Datapath
   // ---------------------------------------------------------------------
   // stage 1: index * INDEX_MULT as partial products (mod 2^64)
   logic [63:0] idx_ll_ff, idx_ll_in;
   logic [31:0] idx_lh_ff, idx_lh_in;
   // stage 2: fold partials, xor identity
   logic [63:0] z0_ff, z0_in;
   // stage 3: add golden gamma, first xor-shift
   logic [63:0] z1_add;
   logic [63:0] x1_ff, x1_in;
   // stage 4: x1 * MIX_M1 partials
   logic [63:0] m1_ll_ff, m1_ll_in;
   logic [31:0] m1_hl_ff, m1_hl_in;
   logic [31:0] m1_lh_ff, m1_lh_in;
   // stage 5: fold, second xor-shift
   logic [63:0] z2_prod;
   logic [63:0] x2_ff, x2_in;
   // stage 6: x2 * MIX_M2 partials
   logic [63:0] m2_ll_ff, m2_ll_in;
   logic [31:0] m2_hl_ff, m2_hl_in;
   logic [31:0] m2_lh_ff, m2_lh_in;
   // stage 7: fold, recentre top 16 bits
   logic [63:0] z3_prod;
   noise_sample_type raw_ff, raw_in;
   // stage 8: gain multiply
   logic signed [34:0] prod_ff, prod_in;
   // stage 9: round half away from zero on the magnitude
   logic [34:0]        mag;
   logic [34:0]        mag_rnd;
   logic               neg_ff, neg_in;
   logic [RMAG_W-1:0]  rmag_ff, rmag_in;
   // stage 10: saturate, output register
   noise_sample_type   out_ff, out_in;

   always_comb begin
      // stage 1
      idx_ll_in = 64'(req_if.sample_index) * 64'(INDEX_MULT[31:0]);
      idx_lh_in = 32'(req_if.sample_index * INDEX_MULT[63:32]);

      // stage 2
      z0_in = {idx_ll_ff[63:32] + idx_lh_ff, idx_ll_ff[31:0]} ^ identity;

      // stage 3
      z1_add = z0_ff + MIX_ADD;
      x1_in  = z1_add ^ (z1_add >> 30);

      // stage 4
      m1_ll_in = 64'(x1_ff[31:0]) * 64'(MIX_M1[31:0]);
      m1_hl_in = 32'(x1_ff[63:32] * MIX_M1[31:0]);
      m1_lh_in = 32'(x1_ff[31:0]  * MIX_M1[63:32]);

      // stage 5
      z2_prod = {m1_ll_ff[63:32] + m1_hl_ff + m1_lh_ff, m1_ll_ff[31:0]};
      x2_in   = z2_prod ^ (z2_prod >> 27);

      // stage 6
      m2_ll_in = 64'(x2_ff[31:0]) * 64'(MIX_M2[31:0]);
      m2_hl_in = 32'(x2_ff[63:32] * MIX_M2[31:0]);
      m2_lh_in = 32'(x2_ff[31:0]  * MIX_M2[63:32]);

      // stage 7: the final >>31 xor never reaches bits 63:48, so the top
      // half-word is taken straight from the product; minus 32768 flips msb
      z3_prod = {m2_ll_ff[63:32] + m2_hl_ff + m2_lh_ff, m2_ll_ff[31:0]};
      raw_in  = noise_sample_type'({~z3_prod[63], z3_prod[62:48]});

      // stage 8
      prod_in = 35'(raw_ff) * 35'(gain_ff);

      // stage 9
      neg_in  = prod_ff[34];
      mag     = prod_ff[34] ? 35'(-prod_ff) : 35'(prod_ff);
      mag_rnd = mag + ROUND_HALF;
      rmag_in = mag_rnd[15 +: RMAG_W];

      // stage 10
      if (!neg_ff) begin
         out_in = (rmag_ff > RMAG_W'(SAMPLE_MAX)) ? SAMPLE_MAX
                                                  : noise_sample_type'(rmag_ff[15:0]);
      end else begin
         out_in = (rmag_ff > RMAG_W'(32768)) ? SAMPLE_MIN
                                             : noise_sample_type'(-rmag_ff[15:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         idx_ll_ff <= idx_ll_in;
         idx_lh_ff <= idx_lh_in;
      end
      if (stage_en[1]) begin
         z0_ff <= z0_in;
      end
      if (stage_en[2]) begin
         x1_ff <= x1_in;
      end
      if (stage_en[3]) begin
         m1_ll_ff <= m1_ll_in;
         m1_hl_ff <= m1_hl_in;
         m1_lh_ff <= m1_lh_in;
      end
      if (stage_en[4]) begin
         x2_ff <= x2_in;
      end
      if (stage_en[5]) begin
         m2_ll_ff <= m2_ll_in;
         m2_hl_ff <= m2_hl_in;
         m2_lh_ff <= m2_lh_in;
      end
      if (stage_en[6]) begin
         raw_ff <= raw_in;
      end
      if (stage_en[7]) begin
         prod_ff <= prod_in;
      end
      if (stage_en[8]) begin
         neg_ff  <= neg_in;
         rmag_ff <= rmag_in;
      end
      if (stage_en[9]) begin
         out_ff <= out_in;
      end
   end

   // ---------------------------------------------------------------------
   // Response
   // ---------------------------------------------------------------------
   assign rsp_if.valid        = valid_ff[STAGE_COUNT-1];
   assign rsp_if.noise_sample = out_ff;
   assign rsp_if.last_out     = last_pipe_ff[STAGE_COUNT-1];

endmodule : counter_noise_sample_generator_top

`default_nettype wire

// ===== hw/rtl/cnsg_checker.sv =====
// ----------------------------------------------------------------------------
// cnsg_checker
// Port-level checks on the noise generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cnsg_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire cnsg_pkg::noise_sample_type rsp_noise_sample,
   input wire logic                       rsp_last_out
);
   import cnsg_pkg::*;

   // reset empties the pipeline
   `CNSG_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "response valid after reset")

   // a stalled response beat stays offered
   `CNSG_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid, "response beat dropped while stalled")

   // and keeps its payload
   `CNSG_ASSERT(a_rsp_stable, clock, reset, (rsp_valid && !rsp_ready) |=> ($stable(rsp_noise_sample) && $stable(rsp_last_out)), "stalled response payload changed")

   // a draining or empty output stage never back-pressures the request side
   `CNSG_ASSERT(a_req_flow, clock, reset, (!rsp_valid || rsp_ready) |-> req_ready, "request stalled while output drains")

   // req_valid is observed for completeness of the port view
   logic req_seen;
   assign req_seen = req_valid && req_ready;
   `CNSG_ASSERT(a_req_beat, clock, reset, req_seen |-> req_ready, "request beat without ready")

endmodule : cnsg_checker

bind counter_noise_sample_generator_top cnsg_checker u_cnsg_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_noise_sample (rsp_if.noise_sample),
   .rsp_last_out     (rsp_if.last_out)
);

`default_nettype wire
